// ----- src/bfl_pkg.sv -----
package bfl_pkg;

  // Default sizes
  localparam int KEY_BYTES_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int MID_DEPTH       = 4;
  localparam int OUT_DEPTH       = 2;

  // Key register file: two 64-bit key words
  localparam int KEY_STORE_BITS = 128;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_ADDR_BITS  = 5;

  // Register indexes (byte address 8*index)
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND       = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND   = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED   = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_NAME,
    PH_LENGTH,
    PH_SKIP,
    PH_DONE
  } phase_t;

  // How the value of an element is skipped
  typedef enum logic [2:0] {
    KIND_FIXED,
    KIND_STRING,
    KIND_DOCUMENT,
    KIND_BINARY,
    KIND_UNSUPPORTED
  } tag_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element_offset;
    logic [7:0]  element_tag;
  } out_item_t;

  // Byte plus its meaning if it is read as a type tag
  typedef struct packed {
    in_item_t   item;
    tag_kind_t  kind;
    logic [4:0] fixed_width;
  } cls_item_t;

endpackage

// ----- src/bfl_fifo.sv -----
module bfl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full    = (cnt_r == CNT_BITS'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/bfl_front.sv -----
module bfl_front (
  input  logic                push,
  input  bfl_pkg::in_item_t   in_item,
  output logic                full,
  input  logic                mid_full,
  output logic                mid_push,
  output bfl_pkg::cls_item_t  mid_data
);

  bfl_pkg::tag_kind_t kind;
  logic [4:0]         fixed_width;

  // Value class of the byte, taken as a type tag
  always_comb begin
    kind        = bfl_pkg::KIND_FIXED;
    fixed_width = 5'd0;
    case (in_item.data_byte)
      8'h01: fixed_width = 5'd8;
      8'h02: kind = bfl_pkg::KIND_STRING;
      8'h03: kind = bfl_pkg::KIND_DOCUMENT;
      8'h04: kind = bfl_pkg::KIND_DOCUMENT;
      8'h05: kind = bfl_pkg::KIND_BINARY;
      8'h06: fixed_width = 5'd0;
      8'h07: fixed_width = 5'd12;
      8'h08: fixed_width = 5'd1;
      8'h09: fixed_width = 5'd8;
      8'h0A: fixed_width = 5'd0;
      8'h10: fixed_width = 5'd4;
      8'h11: fixed_width = 5'd8;
      8'h12: fixed_width = 5'd8;
      8'h13: fixed_width = 5'd16;
      8'h7F: fixed_width = 5'd0;
      8'hFF: fixed_width = 5'd0;
      default: kind = bfl_pkg::KIND_UNSUPPORTED;
    endcase
  end

  // Request goes straight into the decoupling queue
  assign full                 = mid_full;
  assign mid_push             = push;
  assign mid_data.item        = in_item;
  assign mid_data.kind        = kind;
  assign mid_data.fixed_width = fixed_width;

endmodule

// ----- src/bfl_scan.sv -----
module bfl_scan #(
  parameter int KEY_BYTES   = bfl_pkg::KEY_BYTES_DEF,
  parameter int OFFSET_BITS = bfl_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mid_empty,
  input  bfl_pkg::cls_item_t     mid_data,
  output logic                   mid_pop,
  input  logic                   out_full,
  output logic                   out_push,
  output bfl_pkg::out_item_t     out_data,
  input  logic [KEY_BYTES*8-1:0] key,
  input  logic [4:0]             key_length
);

  bfl_pkg::phase_t    phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [7:0]         tag_r, tag_nxt;
  bfl_pkg::tag_kind_t kind_r, kind_nxt;
  logic [4:0]         fixed_w_r, fixed_w_nxt;
  logic [4:0]         name_pos_r, name_pos_nxt;
  logic               name_eq_r, name_eq_nxt;
  logic [31:0]        len_word_r, len_word_nxt;
  logic [1:0]         len_cnt_r, len_cnt_nxt;
  logic [31:0]        skip_r, skip_nxt;

  logic [bfl_pkg::KEY_STORE_BITS-1:0] key_ext;
  logic [4:0]  len_clamp;
  logic [7:0]  expect_byte;
  logic [7:0]  b;
  logic        last;
  logic        fire;
  logic        name_eq_new;
  logic [31:0] len_value;
  logic [31:0] rest;
  logic [31:0] skip_dec;
  logic        emit;

  assign fire     = ~mid_empty & ~out_full;
  assign mid_pop  = fire;
  assign b        = mid_data.item.data_byte;
  assign last     = mid_data.item.last_byte;
  assign key_ext  = bfl_pkg::KEY_STORE_BITS'(key);

  // Key byte expected at the current name position
  assign len_clamp   = (key_length > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : key_length;
  assign expect_byte = (name_pos_r < len_clamp) ?
                       key_ext[{name_pos_r[3:0], 3'b000} +: 8] : 8'h00;
  assign name_eq_new = name_eq_r & (b == expect_byte);

  // Little-endian length word, bytes shift in from the top
  assign len_value = {b, len_word_r[31:8]};
  assign skip_dec  = (skip_r != '0) ? skip_r - 1'b1 : '0;

  // Bytes left after the length word
  always_comb begin
    rest = '0;
    if (!len_value[31]) begin
      case (kind_r)
        bfl_pkg::KIND_STRING: rest = len_value;
        bfl_pkg::KIND_BINARY: rest = len_value + 1'b1;
        default:              rest = (len_value >= 32'd4) ? len_value - 32'd4 : '0;
      endcase
    end
  end

  // Next scan phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        bfl_pkg::PH_HEADER: begin
          if (pos_r >= OFFSET_BITS'(3)) phase_nxt = bfl_pkg::PH_TAG;
        end
        bfl_pkg::PH_TAG: begin
          phase_nxt = (b == 8'h00) ? bfl_pkg::PH_DONE : bfl_pkg::PH_NAME;
        end
        bfl_pkg::PH_NAME: begin
          if (b == 8'h00) begin
            if (name_eq_new || kind_r == bfl_pkg::KIND_UNSUPPORTED) begin
              phase_nxt = bfl_pkg::PH_DONE;
            end else if (kind_r == bfl_pkg::KIND_FIXED) begin
              phase_nxt = (fixed_w_r == '0) ? bfl_pkg::PH_TAG : bfl_pkg::PH_SKIP;
            end else begin
              phase_nxt = bfl_pkg::PH_LENGTH;
            end
          end
        end
        bfl_pkg::PH_LENGTH: begin
          if (len_cnt_r == 2'd3) begin
            phase_nxt = (rest == '0) ? bfl_pkg::PH_TAG : bfl_pkg::PH_SKIP;
          end
        end
        bfl_pkg::PH_SKIP: begin
          if (skip_dec == '0) phase_nxt = bfl_pkg::PH_TAG;
        end
        default: phase_nxt = phase_r;
      endcase
      if (last) phase_nxt = bfl_pkg::PH_HEADER;
    end
  end

  // Datapath and result
  always_comb begin
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    tag_nxt      = tag_r;
    kind_nxt     = kind_r;
    fixed_w_nxt  = fixed_w_r;
    name_pos_nxt = name_pos_r;
    name_eq_nxt  = name_eq_r;
    len_word_nxt = len_word_r;
    len_cnt_nxt  = len_cnt_r;
    skip_nxt     = skip_r;
    emit         = 1'b0;
    out_data     = '0;
    if (fire) begin
      pos_nxt = pos_r + 1'b1;
      case (phase_r)
        bfl_pkg::PH_TAG: begin
          if (b == 8'h00) begin
            emit            = 1'b1;
            out_data.status = bfl_pkg::STATUS_NOT_FOUND;
          end else begin
            start_nxt    = pos_r;
            tag_nxt      = b;
            kind_nxt     = mid_data.kind;
            fixed_w_nxt  = mid_data.fixed_width;
            name_pos_nxt = '0;
            name_eq_nxt  = 1'b1;
          end
        end
        bfl_pkg::PH_NAME: begin
          name_eq_nxt = name_eq_new;
          if (b != 8'h00) begin
            if (name_pos_r != 5'd31) name_pos_nxt = name_pos_r + 1'b1;
          end else if (name_eq_new || kind_r == bfl_pkg::KIND_UNSUPPORTED) begin
            emit                    = 1'b1;
            out_data.status         = name_eq_new ? bfl_pkg::STATUS_FOUND :
                                                    bfl_pkg::STATUS_UNSUPPORTED;
            out_data.element_offset = 32'(start_r);
            out_data.element_tag    = tag_r;
          end else if (kind_r == bfl_pkg::KIND_FIXED) begin
            skip_nxt = 32'(fixed_w_r);
          end else begin
            len_word_nxt = '0;
            len_cnt_nxt  = '0;
          end
        end
        bfl_pkg::PH_LENGTH: begin
          len_word_nxt = len_value;
          if (len_cnt_r == 2'd3) begin
            len_cnt_nxt = '0;
            skip_nxt    = rest;
          end else begin
            len_cnt_nxt = len_cnt_r + 1'b1;
          end
        end
        bfl_pkg::PH_SKIP: skip_nxt = skip_dec;
        default: ;
      endcase
      // End of buffer: report truncation if nothing yet, then rearm
      if (last) begin
        if (!emit && phase_r != bfl_pkg::PH_DONE) begin
          emit            = 1'b1;
          out_data        = '0;
          out_data.status = bfl_pkg::STATUS_TRUNCATED;
        end
        pos_nxt      = '0;
        start_nxt    = '0;
        tag_nxt      = '0;
        kind_nxt     = bfl_pkg::KIND_FIXED;
        fixed_w_nxt  = '0;
        name_pos_nxt = '0;
        name_eq_nxt  = 1'b1;
        len_word_nxt = '0;
        len_cnt_nxt  = '0;
        skip_nxt     = '0;
      end
    end
  end

  assign out_push = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= bfl_pkg::PH_HEADER;
      pos_r      <= '0;
      start_r    <= '0;
      tag_r      <= '0;
      kind_r     <= bfl_pkg::KIND_FIXED;
      fixed_w_r  <= '0;
      name_pos_r <= '0;
      name_eq_r  <= 1'b1;
      len_word_r <= '0;
      len_cnt_r  <= '0;
      skip_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      tag_r      <= tag_nxt;
      kind_r     <= kind_nxt;
      fixed_w_r  <= fixed_w_nxt;
      name_pos_r <= name_pos_nxt;
      name_eq_r  <= name_eq_nxt;
      len_word_r <= len_word_nxt;
      len_cnt_r  <= len_cnt_nxt;
      skip_r     <= skip_nxt;
    end
  end

endmodule

// ----- src/bson_field_locator.sv -----
// Scans a BSON document streamed in one byte per request and reports the first
// top-level element whose name equals the configured key: found (with the
// element's tag offset and tag), not found at the end marker, unsupported type,
// or truncated when the byte marked last arrives first. The scanner takes a byte
// whenever one is queued and the result queue has room; a four-entry queue separates
// byte intake from the scanner, and a two-entry result queue lets the scanner keep
// running while a result waits, so a byte can be pushed every cycle while the byte
// queue has room. The scanner holds only while two results wait unread. The byte
// queue feeds the scanner, which writes each result into the result queue; the
// ports show it once earlier results are read. The byte marked last always rearms
// the scan for the next document. Write the key registers only while idle.
module bson_field_locator #(
  parameter int KEY_BYTES   = bfl_pkg::KEY_BYTES_DEF,
  parameter int OFFSET_BITS = bfl_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Byte input queue
  input  logic                              push,
  output logic                              full,
  input  bfl_pkg::in_item_t                 in_item,
  // Result queue
  output logic                              empty,
  input  logic                              pop,
  output bfl_pkg::out_item_t                out_item,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfl_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [bfl_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [bfl_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  localparam int MID_W = $bits(bfl_pkg::cls_item_t);
  localparam int OUT_W = $bits(bfl_pkg::out_item_t);

  logic [KEY_BYTES*8-1:0] key_r, key_nxt;
  logic [4:0]             key_len_r, key_len_nxt;
  logic [bfl_pkg::KEY_STORE_BITS-1:0] key_ext, key_upd;
  logic [1:0]             reg_idx;
  logic                   wr_en;

  logic               mid_push, mid_full, mid_pop, mid_empty;
  bfl_pkg::cls_item_t mid_wdata, mid_rdata;
  logic [MID_W-1:0]   mid_rbits;
  logic               res_push, res_full;
  bfl_pkg::out_item_t res_wdata;
  logic [OUT_W-1:0]   res_rbits;

  // Register port decode
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:3];
  assign key_ext = bfl_pkg::KEY_STORE_BITS'(key_r);

  always_comb begin
    key_upd     = key_ext;
    key_len_nxt = key_len_r;
    if (wr_en) begin
      case (reg_idx)
        bfl_pkg::REG_KEY_LOW:  key_upd[63:0]   = pwdata;
        bfl_pkg::REG_KEY_HIGH: key_upd[127:64] = pwdata;
        bfl_pkg::REG_KEY_LEN:  key_len_nxt     = pwdata[4:0];
        default: ;
      endcase
    end
    key_nxt = key_upd[KEY_BYTES*8-1:0];
  end

  always_comb begin
    case (reg_idx)
      bfl_pkg::REG_KEY_LOW:  prdata = key_ext[63:0];
      bfl_pkg::REG_KEY_HIGH: prdata = key_ext[127:64];
      bfl_pkg::REG_KEY_LEN:  prdata = bfl_pkg::CFG_DATA_BITS'(key_len_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      key_len_r <= '0;
    end else begin
      key_r     <= key_nxt;
      key_len_r <= key_len_nxt;
    end
  end

  // Intake and tag classification
  bfl_front u_front (
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  bfl_fifo #(
    .WIDTH (MID_W),
    .DEPTH (bfl_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rbits),
    .empty   (mid_empty)
  );

  assign mid_rdata = bfl_pkg::cls_item_t'(mid_rbits);

  // Element walker
  bfl_scan #(
    .KEY_BYTES   (KEY_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_empty  (mid_empty),
    .mid_data   (mid_rdata),
    .mid_pop    (mid_pop),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_data   (res_wdata),
    .key        (key_r),
    .key_length (key_len_r)
  );

  bfl_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (bfl_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wdata),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rbits),
    .empty   (empty)
  );

  assign out_item = bfl_pkg::out_item_t'(res_rbits);

endmodule

// ----- tb/bson_field_locator_tb.sv -----
`timescale 1ns / 1ps

module bson_field_locator_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int QUIET_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;

  // Clock, reset and block ports
  logic                              clk;
  logic                              rst_n    = 1'b0;
  logic                              push     = 1'b0;
  logic                              full;
  bfl_pkg::in_item_t                 in_item  = '0;
  logic                              empty;
  logic                              pop      = 1'b0;
  bfl_pkg::out_item_t                out_item;
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [bfl_pkg::CFG_ADDR_BITS-1:0] paddr    = '0;
  logic [bfl_pkg::CFG_DATA_BITS-1:0] pwdata   = '0;
  logic [bfl_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                              pready;

  // Scanner mirror: key registers and scan state
  logic [63:0]      key_lo;
  logic [63:0]      key_hi;
  logic [4:0]       key_len;
  bfl_pkg::phase_t  scan_phase;
  logic [31:0]      byte_pos;
  logic [31:0]      elem_start;
  logic [7:0]       cur_tag;
  logic [4:0]       name_pos;
  logic             name_eq;
  logic [31:0]      len_word;
  logic [1:0]       len_cnt;
  logic [31:0]      skip_left;
  logic             result_given;

  bfl_pkg::out_item_t expected_results[$];
  logic [7:0]         doc_bytes[$];

  // Run bookkeeping
  int error_count = 0;
  int bytes_sent  = 0;
  int docs_sent   = 0;
  int results_seen = 0;
  int status_seen[4];
  int key_settings = 0;
  int cycle_count = 0;

  // Sender burst shaping
  int burst_left = 0;
  int max_gap    = 4;

  // Receiver stall pattern and long hold-off
  int rx_mode    = 0;
  int mode_left  = 0;
  int hold_len   = 0;
  int hold_left  = 0;
  bfl_pkg::out_item_t rx_want;

  bson_field_locator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               expected_results.size());
      $display("bson_field_locator regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  function automatic logic [7:0] key_byte(input int idx);
    if (idx < 8) return key_lo[8*idx +: 8];
    if (idx < 16) return key_hi[8*(idx-8) +: 8];
    return 8'h00;
  endfunction

  // How a value following the given tag is skipped; width for fixed kinds
  function automatic bfl_pkg::tag_kind_t kind_of(input logic [7:0] tag, output int width);
    width = 0;
    case (tag)
      8'h01, 8'h09, 8'h11, 8'h12: begin
        width = 8;
        return bfl_pkg::KIND_FIXED;
      end
      8'h02: return bfl_pkg::KIND_STRING;
      8'h03, 8'h04: return bfl_pkg::KIND_DOCUMENT;
      8'h05: return bfl_pkg::KIND_BINARY;
      8'h06, 8'h0A, 8'h7F, 8'hFF: return bfl_pkg::KIND_FIXED;
      8'h07: begin
        width = 12;
        return bfl_pkg::KIND_FIXED;
      end
      8'h08: begin
        width = 1;
        return bfl_pkg::KIND_FIXED;
      end
      8'h10: begin
        width = 4;
        return bfl_pkg::KIND_FIXED;
      end
      8'h13: begin
        width = 16;
        return bfl_pkg::KIND_FIXED;
      end
      default: return bfl_pkg::KIND_UNSUPPORTED;
    endcase
  endfunction

  function automatic void clear_scan();
    scan_phase   = bfl_pkg::PH_HEADER;
    byte_pos     = '0;
    elem_start   = '0;
    cur_tag      = '0;
    name_pos     = '0;
    name_eq      = 1'b1;
    len_word     = '0;
    len_cnt      = '0;
    skip_left    = '0;
    result_given = 1'b0;
  endfunction

  function automatic void start_skip(input logic [31:0] count);
    skip_left  = count;
    scan_phase = (count == 0) ? bfl_pkg::PH_TAG : bfl_pkg::PH_SKIP;
  endfunction

  // Advance the mirror by one accepted byte; queue the result it settles
  function automatic void scan_byte(input bfl_pkg::in_item_t it);
    logic [7:0]         b;
    logic [31:0]        pos;
    logic [31:0]        rest;
    logic [7:0]         want;
    int                 klen;
    int                 w;
    bfl_pkg::tag_kind_t kind;
    bfl_pkg::out_item_t res;
    bit                 has_res;
    b       = it.data_byte;
    pos     = byte_pos;
    has_res = 1'b0;
    res     = '0;
    case (scan_phase)
      bfl_pkg::PH_HEADER: if (pos >= 3) scan_phase = bfl_pkg::PH_TAG;
      bfl_pkg::PH_TAG: begin
        if (b == 8'h00) begin
          res     = '{bfl_pkg::STATUS_NOT_FOUND, 32'd0, 8'd0};
          has_res = 1'b1;
        end else begin
          elem_start = pos;
          cur_tag    = b;
          name_pos   = '0;
          name_eq    = 1'b1;
          scan_phase = bfl_pkg::PH_NAME;
        end
      end
      bfl_pkg::PH_NAME: begin
        klen = (key_len > bfl_pkg::KEY_BYTES_DEF) ? bfl_pkg::KEY_BYTES_DEF : int'(key_len);
        want = (int'(name_pos) < klen) ? key_byte(int'(name_pos)) : 8'h00;
        if (b != want) name_eq = 1'b0;
        kind = kind_of(cur_tag, w);
        if (b != 8'h00) begin
          if (name_pos < 5'd31) name_pos++;
        end else if (name_eq) begin
          // a name match wins even over an unsupported type
          res     = '{bfl_pkg::STATUS_FOUND, elem_start, cur_tag};
          has_res = 1'b1;
        end else if (kind == bfl_pkg::KIND_UNSUPPORTED) begin
          res     = '{bfl_pkg::STATUS_UNSUPPORTED, elem_start, cur_tag};
          has_res = 1'b1;
        end else if (kind == bfl_pkg::KIND_FIXED) begin
          start_skip(32'(w));
        end else begin
          len_word   = '0;
          len_cnt    = '0;
          scan_phase = bfl_pkg::PH_LENGTH;
        end
      end
      bfl_pkg::PH_LENGTH: begin
        len_word[8*int'(len_cnt) +: 8] = b;
        if (len_cnt == 2'd3) begin
          // negative or short lengths skip nothing past the length word
          rest = '0;
          kind = kind_of(cur_tag, w);
          if (!len_word[31]) begin
            if (kind == bfl_pkg::KIND_STRING) rest = len_word;
            else if (kind == bfl_pkg::KIND_BINARY) rest = len_word + 32'd1;
            else if (len_word >= 32'd4) rest = len_word - 32'd4;
          end
          len_cnt = '0;
          start_skip(rest);
        end else begin
          len_cnt++;
        end
      end
      bfl_pkg::PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) scan_phase = bfl_pkg::PH_TAG;
      end
      default: ;
    endcase
    if (has_res) begin
      result_given = 1'b1;
      scan_phase   = bfl_pkg::PH_DONE;
    end
    byte_pos = pos + 32'd1;
    if (it.last_byte) begin
      if (!result_given) begin
        res     = '{bfl_pkg::STATUS_TRUNCATED, 32'd0, 8'd0};
        has_res = 1'b1;
      end
      clear_scan();
    end
    if (has_res) expected_results.push_back(res);
  endfunction

  // Offer one byte; returns at the edge that accepts it
  task automatic send_byte(input bfl_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    scan_byte(it);
    bytes_sent++;
  endtask

  task automatic send_document();
    bfl_pkg::in_item_t it;
    for (int i = 0; i < doc_bytes.size(); i++) begin
      it.data_byte = doc_bytes[i];
      it.last_byte = (i == doc_bytes.size() - 1);
      send_byte(it);
    end
    docs_sent++;
  endtask

  // Stop offering and let every due result drain, then let the pipeline settle
  task automatic wait_quiet();
    push       <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Register write, then read back in the following transfer
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    logic [63:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1) report_mismatch("pready low during a write access");
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bfl_pkg::REG_KEY_LOW:  key_lo = val;
      bfl_pkg::REG_KEY_HIGH: key_hi = val;
      bfl_pkg::REG_KEY_LEN:  key_len = val[4:0];
      default: ;
    endcase
    if (rd !== val)
      report_mismatch($sformatf("register %0d reads %h, written %h", idx, rd, val));
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
    wait_quiet();
    write_reg(bfl_pkg::REG_KEY_LOW, lo);
    write_reg(bfl_pkg::REG_KEY_HIGH, hi);
    write_reg(bfl_pkg::REG_KEY_LEN, {59'd0, len});
    key_settings++;
  endtask

  function automatic logic [63:0] nonzero_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  function automatic void put_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) doc_bytes.push_back(v[8*i +: 8]);
  endfunction

  // One element: tag, name (often the key or a near miss), value
  function automatic void add_element();
    logic [7:0]  known[16] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                               8'h09, 8'h0A, 8'h10, 8'h11, 8'h12, 8'h13, 8'h7F, 8'hFF};
    logic [7:0]  tag;
    logic [7:0]  kb;
    logic [7:0]  name[$];
    logic [31:0] len;
    bfl_pkg::tag_kind_t kind;
    int          pick;
    int          n;
    int          w;
    bit          bad;
    pick = $urandom_range(0, 19);
    if (pick < 15) tag = known[$urandom_range(0, 15)];
    else if (pick < 18) tag = 8'($urandom_range(8'h0B, 8'h0F));
    else tag = 8'($urandom_range(1, 255));
    n = (key_len > bfl_pkg::KEY_BYTES_DEF) ? bfl_pkg::KEY_BYTES_DEF : int'(key_len);
    for (int i = 0; i < n; i++) begin
      kb = key_byte(i);
      if (kb == 8'h00) break;
      name.push_back(kb);
    end
    pick = $urandom_range(0, 9);
    if (pick == 3) begin
      name.push_back(8'($urandom_range(1, 255)));
    end else if (pick == 4) begin
      if (name.size() != 0) void'(name.pop_back());
      else name.push_back(8'h41);
    end else if (pick == 5) begin
      // long name: up to and past the saturation point of the name counter
      n = $urandom_range(30, 40);
      while (name.size() < n) name.push_back(8'($urandom_range(1, 255)));
    end else if (pick > 5) begin
      name.delete();
      repeat ($urandom_range(0, 6)) name.push_back(8'($urandom_range(1, 255)));
    end
    doc_bytes.push_back(tag);
    foreach (name[i]) doc_bytes.push_back(name[i]);
    doc_bytes.push_back(8'h00);
    kind = kind_of(tag, w);
    bad  = ($urandom_range(0, 9) == 0);
    case (kind)
      bfl_pkg::KIND_FIXED: repeat (w) doc_bytes.push_back(8'($urandom));
      bfl_pkg::KIND_STRING, bfl_pkg::KIND_BINARY: begin
        n   = $urandom_range(0, 8);
        len = bad ? {1'b1, 31'($urandom)} : 32'(n);
        put_word(len);
        if (!bad) repeat (n + (kind == bfl_pkg::KIND_BINARY)) doc_bytes.push_back(8'($urandom));
      end
      bfl_pkg::KIND_DOCUMENT: begin
        n = $urandom_range(0, 10);
        if (!bad) len = 32'(n + 4);
        else if ($urandom_range(0, 1) == 1) len = {1'b1, 31'($urandom)};
        else len = $urandom_range(0, 3);
        put_word(len);
        if (!bad) repeat (n) doc_bytes.push_back(8'($urandom));
      end
      default: repeat ($urandom_range(0, 3)) doc_bytes.push_back(8'($urandom));
    endcase
  endfunction

  // Header, a few elements, end marker; sometimes trailing bytes or cut short
  function automatic void build_document();
    int cut;
    doc_bytes.delete();
    put_word($urandom_range(5, 200));
    repeat ($urandom_range(0, 4)) add_element();
    doc_bytes.push_back(8'h00);
    case ($urandom_range(0, 9))
      7: repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom));
      8, 9: begin
        cut = $urandom_range(1, doc_bytes.size());
        while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
      end
      default: ;
    endcase
  endfunction

  // Result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing due: status %0d offset %0d tag %h",
                                  out_item.status, out_item.element_offset,
                                  out_item.element_tag));
      end else begin
        rx_want = expected_results.pop_front();
        status_seen[rx_want.status]++;
        if (out_item.status !== rx_want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_item.status, rx_want.status));
        if (out_item.element_offset !== rx_want.element_offset)
          report_mismatch($sformatf("element_offset %0d, want %0d",
                                    out_item.element_offset, rx_want.element_offset));
        if (out_item.element_tag !== rx_want.element_tag)
          report_mismatch($sformatf("element_tag %h, want %h",
                                    out_item.element_tag, rx_want.element_tag));
      end
    end
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(32, 256);
    end
    mode_left--;
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 4) == 0);
        default: pop <= ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  // Hand-built documents: not found, empty-key match, unsupported type,
  // match on an unsupported type, bytes ignored after a result, truncation
  task automatic test_directed();
    max_gap = 0;
    doc_bytes = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00};
    send_document();
    doc_bytes = '{8'h06, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00};
    send_document();
    load_key(64'h61, 64'h0, 5'd1);
    max_gap = 3;
    doc_bytes = '{8'h07, 8'h00, 8'h00, 8'h00, 8'h0B, 8'h62, 8'h00};
    send_document();
    doc_bytes = '{8'h07, 8'h00, 8'h00, 8'h00, 8'h0D, 8'h61, 8'h00};
    send_document();
    doc_bytes = '{8'h0C, 8'h00, 8'h00, 8'h00, 8'h08, 8'h61, 8'h00, 8'h01};
    send_document();
    doc_bytes = '{8'h10, 8'h00, 8'h00};
    send_document();
  endtask

  // Random documents, some malformed or cut short, under a series of keys, extremes first
  task automatic test_key_settings();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    int          start;
    for (int s = 0; s < 10; s++) begin
      lo = nonzero_word();
      hi = nonzero_word();
      case (s)
        0: begin
          lo  = '0;
          hi  = '0;
          len = 5'd0;
        end
        1: begin
          lo  = '1;
          hi  = '1;
          len = 5'd16;
        end
        2: len = 5'd31;
        3: begin
          lo[31:24] = 8'h00;  // zero byte ends the key early
          len = 5'd8;
        end
        4: len = 5'd1;
        5: len = 5'd12;
        default: begin
          len = 5'($urandom_range(0, 16));
          if ($urandom_range(0, 2) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
          end
        end
      endcase
      load_key(lo, hi, len);
      max_gap = (s % 3 == 0) ? 0 : $urandom_range(1, 8);
      start = bytes_sent;
      while (bytes_sent - start < 90) begin
        build_document();
        send_document();
      end
    end
  endtask

  // Unstructured bytes with random buffer ends
  task automatic test_noise();
    bfl_pkg::in_item_t it;
    max_gap = 6;
    for (int i = 0; i < 150; i++) begin
      it.data_byte = 8'($urandom);
      it.last_byte = (i == 149) || ($urandom_range(0, 19) == 0);
      send_byte(it);
    end
  endtask

  // Receiver holds off while the sender keeps pushing short documents
  task automatic test_backpressure();
    wait_quiet();
    max_gap  = 0;
    hold_len = HOLD_CYCLES;
    repeat (40) begin
      doc_bytes = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00};
      send_document();
    end
    wait_quiet();
    max_gap = 4;
    repeat (4) begin
      build_document();
      send_document();
    end
  endtask

  initial begin
    key_lo  = '0;
    key_hi  = '0;
    key_len = '0;
    clear_scan();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_key_settings();
    test_noise();
    test_backpressure();

    wait_quiet();
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("scanned %0d bytes in %0d documents under %0d key settings, %0d results",
             bytes_sent, docs_sent, key_settings, results_seen);
    $display("found %0d, not found %0d, unsupported %0d, truncated %0d; %0d mismatches",
             status_seen[bfl_pkg::STATUS_FOUND], status_seen[bfl_pkg::STATUS_NOT_FOUND],
             status_seen[bfl_pkg::STATUS_UNSUPPORTED], status_seen[bfl_pkg::STATUS_TRUNCATED],
             error_count);
    if (error_count == 0) begin
      $display("bson_field_locator regression: pass");
    end else begin
      $display("bson_field_locator regression: fail");
    end
    $finish;
  end

endmodule
